// File: hdl/oca_pkg.sv
// Package for the orbit cycle analysis block: map constants and sequencer states.
// No dependencies; used by oca_step and oca_ctrl.
`default_nettype none

package oca_pkg;

  // Width of the result fields on the ports
  localparam int unsigned OUT_W = 16;

  // f(x) = x*x + MAP_MUL*x + MAP_ADD, reduced mod M
  localparam int unsigned MAP_MUL = 37;
  localparam int unsigned MAP_ADD = 7;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_WARM,
    CS_LAM,
    CS_LEAD,
    CS_MU_T,
    CS_MU_L,
    CS_DONE
  } ctrl_state_e;

endpackage

`default_nettype wire

// File: hdl/oca_step.sv
// Shared map unit: one multiply, then a bit-serial restoring reduction mod M.
// Depends on oca_pkg for the map constants.
`default_nettype none

module oca_step #(
  parameter int unsigned XW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [XW-1:0] x_i,
  input  wire logic [XW-1:0] m_i,
  output logic               done_o,
  output logic [XW-1:0]      y_o
);

  // x*(x+37)+7 stays below 2^(2*XW+2) for every XW >= 4
  localparam int unsigned PW = 2 * XW + 2;
  localparam int unsigned FW = 2 * XW + 6;
  localparam int unsigned CW = $clog2(PW);
  localparam logic [CW-1:0] LAST = CW'(PW - 1);

  logic [XW+5:0] xp;
  logic [FW-1:0] prod_full;
  logic [PW-1:0] dvd_q;
  logic [XW-1:0] r_q;
  logic [XW:0]   r_shift;
  logic [XW-1:0] r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  assign xp        = (XW + 6)'(x_i) + (XW + 6)'(oca_pkg::MAP_MUL);
  assign prod_full = FW'(x_i) * FW'(xp) + FW'(oca_pkg::MAP_ADD);

  // one dividend bit per cycle; remainder stays below m
  assign r_shift = {r_q, dvd_q[PW-1]};
  assign r_d     = (r_shift >= {1'b0, m_i}) ? XW'(r_shift - {1'b0, m_i}) : XW'(r_shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q <= prod_full[PW-1:0];
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PW-2:0], 1'b0};
      r_q   <= r_d;
    end
  end

  assign done_o = done_q;
  assign y_o    = r_q;

endmodule

`default_nettype wire

// File: hdl/oca_ctrl.sv
// Sequencer: walks the orbit through the shared map unit and counts mu and lambda.
// Depends on oca_pkg (states) and oca_step.
`default_nettype none

module oca_ctrl #(
  parameter int unsigned XW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [XW-1:0] start_value_i,
  input  wire logic [XW-1:0] modulus_i,
  output logic               res_valid_o,
  input  wire logic          res_take_i,
  output logic [XW-1:0]      mu_o,
  output logic [XW-1:0]      lam_o
);

  oca_pkg::ctrl_state_e state_q, state_d;

  logic [XW-1:0] m_q, m_d;
  logic [XW-1:0] start_q, start_d;
  logic [XW-1:0] ref_q, ref_d;
  logic [XW-1:0] lead_q, lead_d;
  logic [XW-1:0] trail_q, trail_d;
  logic [XW-1:0] cnt_q, cnt_d;
  logic [XW-1:0] lam_q, lam_d;
  logic [XW-1:0] mu_q, mu_d;

  logic          go;
  logic [XW-1:0] x_go;
  logic          done;
  logic [XW-1:0] y;

  oca_step #(
    .XW(XW)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .x_i    (x_go),
    .m_i    (m_q),
    .done_o (done),
    .y_o    (y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oca_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    start_q <= start_d;
    ref_q   <= ref_d;
    lead_q  <= lead_d;
    trail_q <= trail_d;
    cnt_q   <= cnt_d;
    lam_q   <= lam_d;
    mu_q    <= mu_d;
  end

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    start_d     = start_q;
    ref_d       = ref_q;
    lead_d      = lead_q;
    trail_d     = trail_q;
    cnt_d       = cnt_q;
    lam_d       = lam_q;
    mu_d        = mu_q;
    go          = 1'b0;
    x_go        = y;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      oca_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          start_d = start_value_i;
          m_d     = (modulus_i == '0) ? XW'(1) : modulus_i;
          cnt_d   = '0;
          go      = 1'b1;
          x_go    = start_value_i;
          state_d = oca_pkg::CS_WARM;
        end
      end
      // M steps put the walk on the cycle
      oca_pkg::CS_WARM: begin
        if (done) begin
          go = 1'b1;
          if (cnt_q == m_q - XW'(1)) begin
            ref_d   = y;
            lam_d   = XW'(1);
            state_d = oca_pkg::CS_LAM;
          end else begin
            cnt_d = cnt_q + XW'(1);
          end
        end
      end
      // step round the cycle until back at the reference element
      oca_pkg::CS_LAM: begin
        if (done) begin
          go = 1'b1;
          if (y == ref_q) begin
            cnt_d   = '0;
            x_go    = start_q;
            state_d = oca_pkg::CS_LEAD;
          end else begin
            lam_d = lam_q + XW'(1);
          end
        end
      end
      // lead runs lambda steps ahead of the start
      oca_pkg::CS_LEAD: begin
        if (done) begin
          if (cnt_q == lam_q - XW'(1)) begin
            lead_d  = y;
            trail_d = start_q;
            mu_d    = '0;
            if (y == start_q) begin
              state_d = oca_pkg::CS_DONE;
            end else begin
              go      = 1'b1;
              x_go    = start_q;
              state_d = oca_pkg::CS_MU_T;
            end
          end else begin
            go    = 1'b1;
            cnt_d = cnt_q + XW'(1);
          end
        end
      end
      oca_pkg::CS_MU_T: begin
        if (done) begin
          trail_d = y;
          go      = 1'b1;
          x_go    = lead_q;
          state_d = oca_pkg::CS_MU_L;
        end
      end
      oca_pkg::CS_MU_L: begin
        if (done) begin
          lead_d = y;
          mu_d   = mu_q + XW'(1);
          if (y == trail_q) begin
            state_d = oca_pkg::CS_DONE;
          end else begin
            go      = 1'b1;
            x_go    = trail_q;
            state_d = oca_pkg::CS_MU_T;
          end
        end
      end
      oca_pkg::CS_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = oca_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = oca_pkg::CS_IDLE;
      end
    endcase
  end

  assign mu_o  = mu_q;
  assign lam_o = lam_q;

endmodule

`default_nettype wire

// File: hdl/orbit_cycle_analysis.sv
// Top level of the orbit cycle analysis block: modulus register, sequencer, result register.
// Depends on oca_pkg and oca_ctrl.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-----------------------------------
//   input    | in_valid_i   | in_ready_o   | start_value_i
//   output   | out_valid_o  | out_ready_i  | precycle_length_o, cycle_length_o
//   config   | cfg_we_i     | (none)       | cfg_wdata_i (modulus)
//
// Each map step is a bit-serial reduction in the shared unit, then a handover cycle in which
// the next product is formed. An item takes about (M + 2*lambda + 2*mu) steps.
// in_ready_o is high only while the sequencer is idle; one item is in work at a time.
// A finished result sits in the output register, so the next item can start while it waits;
// a second result stalls in the sequencer until the register is free.
// Reset clears control state and sets the modulus to 1.
`default_nettype none

module orbit_cycle_analysis #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] start_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      precycle_length_o,
  output logic [15:0]      cycle_length_o
);

  // ports are 16 bits, so only min(VALUE_WIDTH, 16) bits ever carry information
  localparam int unsigned XW = (VALUE_WIDTH < oca_pkg::OUT_W) ? VALUE_WIDTH : oca_pkg::OUT_W;

  logic [15:0]   modulus_q;
  logic          res_valid;
  logic          res_take;
  logic [XW-1:0] mu;
  logic [XW-1:0] lam;
  logic          out_valid_q;
  logic [15:0]   prec_q;
  logic [15:0]   cyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 16'd1;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  oca_ctrl #(
    .XW(XW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_value_i (start_value_i[XW-1:0]),
    .modulus_i     (modulus_q[XW-1:0]),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .mu_o          (mu),
    .lam_o         (lam)
  );

  // result register: load when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      prec_q <= 16'(mu);
      cyc_q  <= 16'(lam);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign precycle_length_o = prec_q;
  assign cycle_length_o    = cyc_q;

`ifndef SYNTH
  // an accepted item keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again straight after an accept");

  // the sequencer never offers a result while it is taking items
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("result pending while idle");

  // every cycle has at least one element
  a_cycle_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cycle_length_o != 16'd0))
    else $error("zero cycle length");

  // a result is taken into the register only once per item
  a_single_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> !res_valid)
    else $error("result offered twice");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for orbit_cycle_analysis: directed and random start values under several moduli,
// with a built-in predictor of the pre-cycle and cycle lengths and an in-order result check.
// Depends on the RTL in hdl/ (oca_pkg, orbit_cycle_analysis and its submodules).

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Map constants, kept here so the predictor stands apart from the RTL
  localparam longint unsigned ORBIT_MUL = 37;
  localparam longint unsigned ORBIT_ADD = 7;

  // An item needs M + 2*(lambda + mu) <= 3*M + 2 map steps, so the slowest item (M = 65535)
  // stays under 3*65536 steps; the limit allows five times that.
  localparam int unsigned STEP_CYCLES    = 35;
  localparam int unsigned WATCHDOG_LIMIT = 5 * 3 * 65536 * STEP_CYCLES;

  // Settling time after the last result: a few map steps
  localparam int unsigned TAIL_CYCLES = 8 * STEP_CYCLES;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] modulus;
    logic [15:0] precycle;
    logic [15:0] cycle;
  } orbit_lengths_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [15:0] start_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [15:0] precycle_length_o;
  logic [15:0] cycle_length_o;

  orbit_lengths_t pending_lengths[$];  // predicted results, oldest first
  logic [15:0]    modulus_shadow = 16'd1;  // mirrors the modulus register (reset value 1)
  bit             idling = 1'b1;  // random gaps on the input and stalls on the output
  int unsigned    mismatches = 0;
  int unsigned    quiet_cycles = 0;

  orbit_cycle_analysis #(
    .VALUE_WIDTH(16)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_value_i    (start_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .precycle_length_o(precycle_length_o),
    .cycle_length_o   (cycle_length_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // f(x) = (x*x + 37x + 7) mod m, evaluated on 64 bits. Reducing x first keeps the
  // square in range and gives the same residue.
  function automatic longint unsigned orbit_map(input longint unsigned x,
                                                input longint unsigned m);
    longint unsigned r;
    r = x % m;
    return (r * r + ORBIT_MUL * r + ORBIT_ADD) % m;
  endfunction

  // Pre-cycle length mu and cycle length lambda of the orbit of start under the
  // given modulus register value. A zero modulus behaves as 1.
  function automatic orbit_lengths_t predict_orbit(input logic [15:0] modulus_reg,
                                                   input logic [15:0] start);
    longint unsigned m;
    longint unsigned on_cycle;
    longint unsigned probe;
    longint unsigned lead;
    longint unsigned trail;
    longint unsigned lambda;
    longint unsigned mu;
    orbit_lengths_t  res;
    m = (modulus_reg == 16'd0) ? 1 : longint'(modulus_reg);
    // m steps are enough to land on the cycle whatever the tail length
    on_cycle = start;
    for (longint unsigned i = 0; i < m; i++) on_cycle = orbit_map(on_cycle, m);
    probe  = orbit_map(on_cycle, m);
    lambda = 1;
    while (probe != on_cycle) begin
      probe = orbit_map(probe, m);
      lambda++;
    end
    // Lead runs lambda steps ahead; both advance until they meet at the cycle entry
    trail = start;
    lead  = start;
    for (longint unsigned i = 0; i < lambda; i++) lead = orbit_map(lead, m);
    mu = 0;
    while (trail != lead) begin
      trail = orbit_map(trail, m);
      lead  = orbit_map(lead, m);
      mu++;
    end
    res.start    = start;
    res.modulus  = modulus_reg;
    res.precycle = mu[15:0];
    res.cycle    = lambda[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks; all are entered just after a rising edge
  // ---------------------------------------------------------------------------

  // Offer one start value and wait for it to be taken. Valid is left high so the
  // next call can follow in the same step; wait_until_idle lowers it.
  task automatic send_start(input logic [15:0] start);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_value_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    pending_lengths.insert(pending_lengths.size(), predict_orbit(modulus_shadow, start));
  endtask

  // Stop offering items and wait until every predicted result has come back
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block idle
  task automatic write_modulus(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    modulus_shadow = value;
  endtask

  // Start value: mostly inside [0, M), sometimes anything the field allows
  function automatic logic [15:0] pick_start(input logic [15:0] modulus_reg);
    int unsigned m;
    m = (modulus_reg == 16'd0) ? 1 : modulus_reg;
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, m - 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Modulus left at its reset value of 1: everything maps to 0
  task automatic test_reset_modulus();
    send_start(16'h0000);
    send_start(16'hFFFF);
    send_start(16'h8000);
    wait_until_idle();
  endtask

  // A written zero behaves as modulus 1
  task automatic test_zero_modulus();
    write_modulus(16'h0000);
    send_start(16'h0000);
    send_start(16'hFFFF);
    send_start(16'h0005);
    wait_until_idle();
  endtask

  // Tiny moduli, start values at the edges, on and off the residue range
  task automatic test_small_moduli();
    logic [15:0] moduli[2];
    moduli = '{16'd2, 16'd7};
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      send_start(16'h0000);
      send_start(moduli[k] - 16'd1);
      send_start(moduli[k]);  // not below the modulus, can never recur
      send_start(16'h5555);
      send_start(16'hAAAA);
      wait_until_idle();
    end
  endtask

  // Largest modulus with the largest start: one slow item
  task automatic test_widest_modulus();
    write_modulus(16'hFFFF);
    send_start(16'hFFFF);
    wait_until_idle();
  endtask

  // Phases of random moduli, mostly small so items stay short, one mid-sized phase
  task automatic test_random_orbits();
    logic [15:0] m;
    for (int p = 0; p < 8; p++) begin
      if (p == 4) m = 16'($urandom_range(256, 700));
      else if ($urandom_range(0, 1) == 0) m = 16'($urandom_range(1, 16));
      else m = 16'($urandom_range(17, 120));
      idling = ($urandom_range(0, 3) != 0);
      write_modulus(m);
      for (int n = 0; n < 11; n++) send_start(pick_start(m));
      wait_until_idle();
    end
  endtask

  // Last stretch: no gaps, no stalls, items back to back
  task automatic test_streaming();
    logic [15:0] m;
    idling = 1'b0;
    m = 16'($urandom_range(2, 40));
    write_modulus(m);
    for (int n = 0; n < 12; n++) send_start(pick_start(m));
    wait_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_zero_modulus();
    test_small_moduli();
    test_widest_modulus();
    test_random_orbits();
    test_streaming();
    // Anything arriving now was never predicted and is caught by the checker
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Output stalls in random bursts while idling is on
  initial begin
    forever begin
      @(posedge clk_i);
      if (idling && rst_ni && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Result check: each accepted item against the oldest prediction
  always @(posedge clk_i) begin
    orbit_lengths_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lengths.size() == 0) begin
        $display("%0t: unexpected result, expected none, got precycle %0d cycle %0d",
                 $time, precycle_length_o, cycle_length_o);
        mismatches++;
      end else begin
        want = pending_lengths.pop_front();
        if (precycle_length_o !== want.precycle) begin
          $display("%0t: start %0d modulus %0d: precycle_length expected %0d, got %0d",
                   $time, want.start, want.modulus, want.precycle, precycle_length_o);
          mismatches++;
        end
        if (cycle_length_o !== want.cycle) begin
          $display("%0t: start %0d modulus %0d: cycle_length expected %0d, got %0d",
                   $time, want.start, want.modulus, want.cycle, cycle_length_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles without any item accepted on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
